[rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority queue
// Sizes, field widths, item codes and the entry record held by each cell.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // queue size and stored widths
  localparam int CAPACITY      = 64;
  localparam int PRIORITY_BITS = 8;
  localparam int TAG_BITS      = 16;

  // widths of the item fields on the ports
  localparam int PRIO_FIELD_W   = 8;
  localparam int TAG_FIELD_W    = 16;
  localparam int STATUS_FIELD_W = 2;

  // item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SERVE  = 1'b1;

  // result status codes
  typedef enum logic [STATUS_FIELD_W-1:0] {
    ST_SERVED = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // one stored entry
  typedef struct packed {
    logic                     valid;
    logic [PRIORITY_BITS-1:0] prio;
    logic [TAG_BITS-1:0]      tag;
  } entry_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic                     insert;
    logic                     serve;
    logic [PRIORITY_BITS-1:0] prio;
    logic [TAG_BITS-1:0]      tag;
  } op_t;

endpackage

`default_nettype wire

[rtl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry; on insert it keeps, takes the new entry or takes the left
// neighbour's entry; on serve it takes the right neighbour's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire spq_pkg::op_t    op,
  input  wire spq_pkg::entry_t left_entry,
  input  wire logic            left_keep,
  input  wire spq_pkg::entry_t right_entry,
  output spq_pkg::entry_t      cur,
  output logic                 keep
);

  spq_pkg::entry_t cur_next;

  // entry stays in place when it ranks equal or above the new one
  assign keep = cur.valid && (cur.prio >= op.prio);

  // choose next contents
  always_comb begin
    cur_next = cur;
    if (op.insert) begin
      if (!keep) begin
        if (left_keep) begin
          cur_next.valid = 1'b1;
          cur_next.prio  = op.prio;
          cur_next.tag   = op.tag;
        end else begin
          cur_next = left_entry;
        end
      end
    end else if (op.serve) begin
      cur_next = right_entry;
    end
  end

  // entry register, only the valid bit is reset
  always_ff @(posedge clk) begin
    cur.prio <= cur_next.prio;
    cur.tag  <= cur_next.tag;
    if (rst) begin
      cur.valid <= 1'b0;
    end else begin
      cur.valid <= cur_next.valid;
    end
  end

endmodule

`default_nettype wire

[rtl/stable_priority_queue.sv]
// ----------------------------------------------------------------------------
// stable_priority_queue: max priority queue, first come first served on ties
// Usage:
//   Input transactions arrive on s_tvalid/s_tready. s_tuser is the kind
//   (0 insert, 1 serve); s_tdata carries priority_req and tag.
//   An insert goes behind every queued entry of equal or higher priority and
//   gives no result, unless the queue is full: then it is dropped and a
//   result with status full is sent. A serve removes the highest, oldest
//   entry and sends its tag with status served, or status empty when the
//   queue holds nothing.
//   Results leave on m_tvalid/m_tready, tag in m_tdata, status in m_tuser.
// Timing:
//   one transaction per cycle unless a stalled receiver holds a result; the
//   whole chain of cells updates in the cycle of acceptance, and a result
//   appears in the output register in the cycle after its transaction is accepted.
//   When the receiver stalls with a result pending, s_tready drops until the
//   result is taken; a result taken in the same cycle frees the slot at once.
// Reset:
//   rst (synchronous) empties the queue and clears any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // priority_req [7:0], tag [23:8]
  input  wire logic        s_tuser,   // kind [0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // served_tag [15:0]
  output logic [1:0]       m_tuser    // status [1:0]
);

  localparam int CAP = spq_pkg::CAPACITY;

  logic                              s_fire;
  logic                              is_serve;
  logic [spq_pkg::PRIO_FIELD_W-1:0]  in_prio;
  logic [spq_pkg::TAG_FIELD_W-1:0]   in_tag;
  logic                              is_full;
  logic                              is_empty;
  spq_pkg::op_t                      op;
  spq_pkg::entry_t                   cell_q [CAP];
  logic [CAP-1:0]                    keep_vec;
  logic [CAP-1:0]                    vld_vec;

  // input unpacking
  assign in_prio  = s_tdata[spq_pkg::PRIO_FIELD_W-1:0];
  assign in_tag   = s_tdata[spq_pkg::PRIO_FIELD_W +: spq_pkg::TAG_FIELD_W];
  assign is_serve = (s_tuser == spq_pkg::KIND_SERVE);
  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;

  // occupancy: valid slots form a prefix
  assign is_full  = vld_vec[CAP-1];
  assign is_empty = !vld_vec[0];

  // broadcast operation
  always_comb begin
    op.insert = s_fire && !is_serve && !is_full;
    op.serve  = s_fire && is_serve && !is_empty;
    op.prio   = in_prio[spq_pkg::PRIORITY_BITS-1:0];
    op.tag    = in_tag[spq_pkg::TAG_BITS-1:0];
  end

  // chain of cells
  for (genvar g = 0; g < CAP; g++) begin : g_cell
    spq_pkg::entry_t left_e;
    spq_pkg::entry_t right_e;
    logic            left_k;

    if (g == 0) begin : g_head
      assign left_e = '0;
      assign left_k = 1'b1;
    end else begin : g_body
      assign left_e = cell_q[g-1];
      assign left_k = keep_vec[g-1];
    end

    if (g == CAP - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cell_q[g+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (op),
      .left_entry  (left_e),
      .left_keep   (left_k),
      .right_entry (right_e),
      .cur         (cell_q[g]),
      .keep        (keep_vec[g])
    );

    assign vld_vec[g] = cell_q[g].valid;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
      m_tuser  <= spq_pkg::ST_SERVED;
    end else begin
      if (s_fire && is_serve) begin
        m_tvalid <= 1'b1;
        if (is_empty) begin
          m_tdata <= '0;
          m_tuser <= spq_pkg::ST_EMPTY;
        end else begin
          m_tdata <= spq_pkg::TAG_FIELD_W'(cell_q[0].tag);
          m_tuser <= spq_pkg::ST_SERVED;
        end
      end else if (s_fire && is_full) begin
        m_tvalid <= 1'b1;
        m_tdata  <= '0;
        m_tuser  <= spq_pkg::ST_FULL;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // valid slots always form a prefix of the chain
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    ((vld_vec >> 1) & ~vld_vec) == '0)
    else $error("valid slots not contiguous from the head");

  // serve on a non-empty queue gives a served result next cycle
  a_serve: assert property (@(posedge clk) disable iff (rst)
    (s_fire && is_serve && !is_empty) |=> (m_tvalid && m_tuser == spq_pkg::ST_SERVED))
    else $error("serve did not produce a served result");

  // insert into a full queue leaves occupancy untouched
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (s_fire && !is_serve && is_full) |=> $stable(vld_vec))
    else $error("dropped insert changed occupancy");

  // non-served results carry a zero tag
  a_zero_tag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != spq_pkg::ST_SERVED) |-> (m_tdata == '0))
    else $error("non-served result carries a tag");
`endif

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for stable_priority_queue
// Drives insert and serve transactions through the input stream and checks
// every result against a sorted-chain model of the queue kept in the bench.
// A short table covers the empty, tie and extreme cases, then random segments
// fill the queue past full, drain it past empty and mix both.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int NUM_RANDOM  = 400;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DIR_COUNT   = 17;

  // what the queue hands back for one transaction
  typedef struct packed {
    logic [spq_pkg::TAG_FIELD_W-1:0] tag;
    spq_pkg::status_t                status;
  } queue_result_t;

  // one row of the directed table
  typedef struct packed {
    logic                             kind;
    logic [spq_pkg::PRIO_FIELD_W-1:0] prio;
    logic [spq_pkg::TAG_FIELD_W-1:0]  tag;
    bit                               typed;
    queue_result_t                    res;
  } stim_row_t;

  // traffic shape of a random segment
  typedef enum int {
    GEN_FILL,
    GEN_DRAIN,
    GEN_MIXED
  } gen_mode_t;

  // receiver stall patterns
  typedef enum int {
    RX_ALWAYS,
    RX_ALTERNATE,
    RX_RANDOM,
    RX_LONG_STALL
  } rx_mode_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // priority_req [7:0], tag [23:8]
  logic        s_tuser;   // kind [0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;   // served_tag [15:0]
  logic [1:0]  m_tuser;   // status [1:0]

  stable_priority_queue u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // model of the sorted chain: slot 0 is served next
  logic [spq_pkg::PRIORITY_BITS-1:0] chain_prio [spq_pkg::CAPACITY];
  logic [spq_pkg::TAG_BITS-1:0]      chain_tag  [spq_pkg::CAPACITY];
  int                                chain_count = 0;

  queue_result_t pending_results [$];

  int          mismatches = 0;
  int          burst_left = 0;
  int          n_inserts = 0;
  int          n_serves = 0;
  int          n_served = 0;
  int          n_empty = 0;
  int          n_full = 0;
  int unsigned cycle_count = 0;

  // receiver pattern state
  rx_mode_t rx_mode = RX_ALWAYS;
  int       rx_left = 0;
  int       rx_phase = 0;

  // directed cases: empty serves, extremes, ties, ignored serve fields
  stim_row_t dir_rows [DIR_COUNT] = '{
    '{spq_pkg::KIND_SERVE,  8'h00, 16'h0000, 1'b1, '{16'h0000, spq_pkg::ST_EMPTY}},
    '{spq_pkg::KIND_SERVE,  8'hff, 16'hffff, 1'b1, '{16'h0000, spq_pkg::ST_EMPTY}},
    '{spq_pkg::KIND_INSERT, 8'h00, 16'h0000, 1'b0, '{16'h0000, spq_pkg::ST_SERVED}},
    '{spq_pkg::KIND_INSERT, 8'hff, 16'hffff, 1'b0, '{16'h0000, spq_pkg::ST_SERVED}},
    '{spq_pkg::KIND_INSERT, 8'hff, 16'h0001, 1'b0, '{16'h0000, spq_pkg::ST_SERVED}},
    '{spq_pkg::KIND_INSERT, 8'h80, 16'h5555, 1'b0, '{16'h0000, spq_pkg::ST_SERVED}},
    '{spq_pkg::KIND_INSERT, 8'h00, 16'haaaa, 1'b0, '{16'h0000, spq_pkg::ST_SERVED}},
    '{spq_pkg::KIND_INSERT, 8'h7f, 16'h1234, 1'b0, '{16'h0000, spq_pkg::ST_SERVED}},
    '{spq_pkg::KIND_SERVE,  8'h00, 16'hffff, 1'b0, '{16'h0000, spq_pkg::ST_SERVED}},
    '{spq_pkg::KIND_SERVE,  8'hff, 16'h0000, 1'b0, '{16'h0000, spq_pkg::ST_SERVED}},
    '{spq_pkg::KIND_SERVE,  8'h00, 16'h0000, 1'b0, '{16'h0000, spq_pkg::ST_SERVED}},
    '{spq_pkg::KIND_INSERT, 8'h01, 16'h8000, 1'b0, '{16'h0000, spq_pkg::ST_SERVED}},
    '{spq_pkg::KIND_SERVE,  8'h00, 16'h0000, 1'b0, '{16'h0000, spq_pkg::ST_SERVED}},
    '{spq_pkg::KIND_SERVE,  8'h00, 16'h0000, 1'b0, '{16'h0000, spq_pkg::ST_SERVED}},
    '{spq_pkg::KIND_SERVE,  8'h00, 16'h0000, 1'b0, '{16'h0000, spq_pkg::ST_SERVED}},
    '{spq_pkg::KIND_SERVE,  8'h00, 16'h0000, 1'b0, '{16'h0000, spq_pkg::ST_SERVED}},
    '{spq_pkg::KIND_SERVE,  8'h5a, 16'ha5a5, 1'b1, '{16'h0000, spq_pkg::ST_EMPTY}}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // one mismatch line and count it
  task automatic note_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h",
             cycle_count, what, got, want);
    mismatches++;
  endtask

  // advance the chain model by one transaction; returns 1 when a result is due
  function automatic bit queue_step(input logic kind,
                                    input logic [spq_pkg::PRIO_FIELD_W-1:0] prio,
                                    input logic [spq_pkg::TAG_FIELD_W-1:0] tag,
                                    output queue_result_t res);
    logic [spq_pkg::PRIORITY_BITS-1:0] p;
    int                                pos;
    p   = prio[spq_pkg::PRIORITY_BITS-1:0];
    res = '{spq_pkg::TAG_FIELD_W'(0), spq_pkg::ST_SERVED};
    if (kind == spq_pkg::KIND_INSERT) begin
      if (chain_count >= spq_pkg::CAPACITY) begin
        res.status = spq_pkg::ST_FULL;
        return 1'b1;
      end
      // go behind every entry of equal or higher priority
      pos = 0;
      while (pos < chain_count && chain_prio[pos] >= p)
        pos++;
      for (int i = chain_count; i > pos; i--) begin
        chain_prio[i] = chain_prio[i-1];
        chain_tag[i]  = chain_tag[i-1];
      end
      chain_prio[pos] = p;
      chain_tag[pos]  = tag[spq_pkg::TAG_BITS-1:0];
      chain_count++;
      return 1'b0;
    end
    if (chain_count == 0) begin
      res.status = spq_pkg::ST_EMPTY;
      return 1'b1;
    end
    // take slot 0 and move the chain up
    res.tag = spq_pkg::TAG_FIELD_W'(chain_tag[0]);
    for (int i = 0; i + 1 < chain_count; i++) begin
      chain_prio[i] = chain_prio[i+1];
      chain_tag[i]  = chain_tag[i+1];
    end
    chain_count--;
    return 1'b1;
  endfunction

  // offer one transaction in bursts with random gaps, then record what it owes
  task automatic send_item(input logic kind, input logic [spq_pkg::PRIO_FIELD_W-1:0] prio,
                           input logic [spq_pkg::TAG_FIELD_W-1:0] tag, input bit typed,
                           input queue_result_t typed_res);
    int            gap;
    bit            has_res;
    queue_result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {tag, prio};
    do @(posedge clk); while (!s_tready);
    has_res = queue_step(kind, prio, tag, res);
    if (typed)
      pending_results.push_back(typed_res);
    else if (has_res)
      pending_results.push_back(res);
    if (kind == spq_pkg::KIND_INSERT)
      n_inserts++;
    else
      n_serves++;
  endtask

  // receiver stalls in segments of its own
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(10, 60);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_phase <= rx_phase + 1;
    case (rx_mode)
      RX_ALWAYS:    m_tready <= 1'b1;
      RX_ALTERNATE: m_tready <= rx_phase[0];
      RX_RANDOM:    m_tready <= ($urandom_range(0, 3) != 0);
      default:      m_tready <= (rx_phase % 9 == 8);
    endcase
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing pending, tag", m_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser != want.status)
          note_mismatch("status", m_tuser, want.status);
        if (m_tdata != want.tag)
          note_mismatch("served_tag", m_tdata, want.tag);
        case (want.status)
          spq_pkg::ST_SERVED: n_served++;
          spq_pkg::ST_EMPTY:  n_empty++;
          default:            n_full++;
        endcase
      end
    end
  end

  // cycle counter and timeout
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_results.size());
    $display("Some tests failed");
    $finish;
  end

  // stimulus
  initial begin
    gen_mode_t                        mode;
    int                               seg_left;
    logic                             kind;
    logic [spq_pkg::PRIO_FIELD_W-1:0] prio;
    logic [spq_pkg::TAG_FIELD_W-1:0]  tag;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = spq_pkg::KIND_INSERT;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < DIR_COUNT; i++)
      send_item(dir_rows[i].kind, dir_rows[i].prio, dir_rows[i].tag,
                dir_rows[i].typed, dir_rows[i].res);

    // random segments, the first one long enough to overflow the queue
    mode     = GEN_FILL;
    seg_left = 100;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (seg_left == 0) begin
        mode     = gen_mode_t'($urandom_range(0, 2));
        seg_left = $urandom_range(20, 60);
      end
      seg_left--;
      case (mode)
        GEN_FILL:
          kind = ($urandom_range(0, 15) == 0) ? spq_pkg::KIND_SERVE : spq_pkg::KIND_INSERT;
        GEN_DRAIN:
          kind = ($urandom_range(0, 3) == 0) ? spq_pkg::KIND_INSERT : spq_pkg::KIND_SERVE;
        default:
          kind = ($urandom_range(0, 1) == 0) ? spq_pkg::KIND_INSERT : spq_pkg::KIND_SERVE;
      endcase
      // priorities: full range, a few levels for ties, extremes, a narrow band
      case ($urandom_range(0, 3))
        0:       prio = $urandom;
        1:       prio = $urandom_range(0, 3);
        2:       prio = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hff;
        default: prio = 8'h80 + $urandom_range(0, 7);
      endcase
      tag = $urandom;
      send_item(kind, prio, tag, 1'b0, '0);
    end

    // drain and let any stray result show up
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d inserts and %0d serves sent, up to %0d entries queued",
             n_inserts, n_serves, spq_pkg::CAPACITY);
    $display("results checked: %0d served, %0d empty, %0d full; %0d mismatches",
             n_served, n_empty, n_full, mismatches);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

[stable_priority_queue.f]
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
tb/sv/testbench.sv
